/* rtl/trrs_pkg.sv */
`timescale 1ns / 1ps
package trrs_pkg;

  localparam int TASKS_DEF = 4;
  localparam int WINDOW_LEN = 1000;
  localparam int COUNT_MAX = 1023;
  localparam int MEAS_W = 10;
  localparam int DLY_W = 16;
  localparam int OUT_IDX_W = 2;

  // operation codes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_DELAY  = 2'd2;
  localparam logic [1:0] OP_START  = 2'd3;

  // microcode addresses
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] UA_TICK  = 3'd0;
  localparam logic [STEP_W-1:0] UA_WALK  = 3'd1;
  localparam logic [STEP_W-1:0] UA_CHKRD = 3'd2;
  localparam logic [STEP_W-1:0] UA_CHK   = 3'd3;
  localparam logic [STEP_W-1:0] UA_OP    = 3'd4;

  // jump conditions
  localparam logic [1:0] J_NONE    = 2'd0;
  localparam logic [1:0] J_NOTASKS = 2'd1;
  localparam logic [1:0] J_MORE    = 2'd2;

  // delay memory read address select
  localparam logic [1:0] RA_IDX  = 2'd0;
  localparam logic [1:0] RA_IDX1 = 2'd1;
  localparam logic [1:0] RA_CUR  = 2'd2;

  typedef struct packed {
    logic              tick_sel;
    logic              walk;
    logic [1:0]        ra_sel;
    logic              chk;
    logic              op_exec;
    logic              done;
    logic [1:0]        jcond;
    logic [STEP_W-1:0] jtgt;
  } ctl_t;

  typedef struct packed {
    logic no_tasks;
    logic more;
  } sts_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] s);
    ctl_t c;
    c = '0;
    unique case (s)
      UA_TICK: begin
        c.tick_sel = 1'b1;
        c.ra_sel   = RA_IDX;
        c.jcond    = J_NOTASKS;
        c.jtgt     = UA_CHKRD;
      end
      UA_WALK: begin
        c.walk   = 1'b1;
        c.ra_sel = RA_IDX1;
        c.jcond  = J_MORE;
        c.jtgt   = UA_WALK;
      end
      UA_CHKRD: begin
        c.ra_sel = RA_CUR;
      end
      UA_CHK: begin
        c.chk  = 1'b1;
        c.done = 1'b1;
      end
      UA_OP: begin
        c.op_exec = 1'b1;
        c.done    = 1'b1;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

/* rtl/trrs_dmem.sv */
`timescale 1ns / 1ps
module trrs_dmem import trrs_pkg::*; #(
  parameter int IW = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  logic [DLY_W-1:0] wdata,
  input  logic [IW-1:0]    raddr,
  output logic [DLY_W-1:0] rdata
);

  localparam int DEPTH = 1 << IW;

  logic [DLY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DLY_W-1:0] q_r;
  logic             qv_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  // an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      qv_r <= vld_r[raddr];
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

/* rtl/trrs_dp.sv */
`timescale 1ns / 1ps
module trrs_dp import trrs_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [1:0]           in_op,
  input  logic [DLY_W-1:0]     in_delay_ms,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_running_task,
  output logic                 out_idle_selected,
  output logic                 out_create_failed,
  output logic [MEAS_W-1:0]    out_idle_measure
);

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int TW = $clog2(TASKS + 1);

  logic [1:0]       op_r;
  logic [DLY_W-1:0] dly_r;

  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     pre_r, pre_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [TW-1:0]     tot_r, tot_nxt;
  logic              idle_r, idle_nxt;
  logic [TASKS-1:0]  dflag_r, dflag_nxt;
  logic [MEAS_W-1:0] wt_r, wt_nxt;
  logic [MEAS_W-1:0] ent_r, ent_nxt;
  logic [MEAS_W-1:0] res_r, res_nxt;
  logic              vout_r, vout_nxt;
  logic              fail_r, fail_nxt;

  logic              we;
  logic [IW-1:0]     waddr;
  logic [DLY_W-1:0]  wdata;
  logic [IW-1:0]     raddr;
  logic [DLY_W-1:0]  rdata;

  logic [TW-1:0]     nx;
  logic [TW-1:0]     idx_inc;
  logic [MEAS_W-1:0] wt_inc;
  logic [IW+OUT_IDX_W-1:0] cur_ext;

  trrs_dmem #(.IW(IW)) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      dly_r <= in_delay_ms;
    end
  end

  assign idx_inc      = TW'(idx_r) + TW'(1);
  assign sts.no_tasks = (tot_r == '0);
  assign sts.more     = (idx_inc < tot_r);
  assign wt_inc       = wt_r + MEAS_W'(1);
  assign nx           = TW'(idle_r ? pre_r : cur_r) + TW'(1);

  always_comb begin
    unique case (ctl.ra_sel)
      RA_IDX:  raddr = idx_r;
      RA_IDX1: raddr = idx_inc[IW-1:0];
      RA_CUR:  raddr = cur_r;
      default: raddr = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata - DLY_W'(1);
    if (ctl.walk && rdata != '0) begin
      we = 1'b1;
    end else if (ctl.op_exec && op_r == OP_DELAY && !idle_r) begin
      we    = 1'b1;
      waddr = cur_r;
      wdata = dly_r;
    end
  end

  always_comb begin
    cur_nxt   = cur_r;
    pre_nxt   = pre_r;
    idx_nxt   = idx_r;
    tot_nxt   = tot_r;
    idle_nxt  = idle_r;
    dflag_nxt = dflag_r;
    wt_nxt    = wt_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    vout_nxt  = ctl.done;
    fail_nxt  = 1'b0;

    if (ctl.tick_sel) begin
      idle_nxt = 1'b0;
      cur_nxt  = (nx >= tot_r) ? '0 : nx[IW-1:0];
      if (wt_inc >= MEAS_W'(WINDOW_LEN)) begin
        res_nxt = ent_r;
        ent_nxt = '0;
        wt_nxt  = '0;
      end else begin
        wt_nxt = wt_inc;
      end
    end

    if (ctl.walk) begin
      idx_nxt = idx_inc[IW-1:0];
    end

    if (ctl.chk && dflag_r[cur_r]) begin
      if (rdata != '0) begin
        pre_nxt  = cur_r;
        idle_nxt = 1'b1;
        if (ent_r != MEAS_W'(COUNT_MAX)) begin
          ent_nxt = ent_r + MEAS_W'(1);
        end
      end else begin
        dflag_nxt[cur_r] = 1'b0;
      end
    end

    if (ctl.op_exec) begin
      unique case (op_r)
        OP_CREATE: begin
          if (tot_r >= TW'(TASKS)) begin
            fail_nxt = 1'b1;
          end else begin
            cur_nxt                   = tot_r[IW-1:0];
            dflag_nxt[tot_r[IW-1:0]]  = 1'b0;
            tot_nxt                   = tot_r + TW'(1);
            idle_nxt                  = 1'b0;
          end
        end
        OP_DELAY: begin
          if (!idle_r) begin
            dflag_nxt[cur_r] = 1'b1;
          end
        end
        OP_START: begin
          cur_nxt  = '0;
          idle_nxt = 1'b0;
          wt_nxt   = '0;
          ent_nxt  = '0;
          res_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    // walk index rests at zero between items
    if (ctl.done) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '0;
      pre_r   <= '0;
      idx_r   <= '0;
      tot_r   <= '0;
      idle_r  <= 1'b0;
      dflag_r <= '0;
      wt_r    <= '0;
      ent_r   <= '0;
      res_r   <= '0;
      vout_r  <= 1'b0;
      fail_r  <= 1'b0;
    end else begin
      cur_r   <= cur_nxt;
      pre_r   <= pre_nxt;
      idx_r   <= idx_nxt;
      tot_r   <= tot_nxt;
      idle_r  <= idle_nxt;
      dflag_r <= dflag_nxt;
      wt_r    <= wt_nxt;
      ent_r   <= ent_nxt;
      res_r   <= res_nxt;
      vout_r  <= vout_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign cur_ext           = {{OUT_IDX_W{1'b0}}, cur_r};
  assign out_valid         = vout_r;
  assign out_running_task  = cur_ext[OUT_IDX_W-1:0];
  assign out_idle_selected = idle_r;
  assign out_create_failed = fail_r;
  assign out_idle_measure  = res_r;

endmodule

/* rtl/trrs_useq.sv */
`timescale 1ns / 1ps
module trrs_useq import trrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  sts_t       sts,
  output logic       busy,
  output ctl_t       ctl
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  ctl_t              cw;
  logic              take;

  assign cw = ucode(step_r);

  always_comb begin
    unique case (cw.jcond)
      J_NOTASKS: take = sts.no_tasks;
      J_MORE:    take = sts.more;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = (in_op == OP_TICK) ? UA_TICK : UA_OP;
      end
    end else if (cw.done) begin
      busy_nxt = 1'b0;
    end else begin
      step_nxt = take ? cw.jtgt : step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= UA_TICK;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign ctl  = busy_r ? cw : '0;

endmodule

/* rtl/tick_round_robin_scheduler_top.sv */
`timescale 1ns / 1ps
// round-robin task selector driven by scheduler ticks
// command: drive in_op / in_delay_ms and raise start; the beat is taken at a
//   rising edge with start high and busy low. busy stays high while the
//   command runs.
// ops: tick advances the selector and counts down every task delay,
//   create registers a task, delay arms the current task unless idle is
//   selected, start selects task 0 and clears the idle statistics.
// result: one beat per command, out_valid high for exactly one cycle; the
//   receiver cannot stall and must take it then. out_running_task,
//   out_idle_selected and out_idle_measure keep their values until the next
//   command changes them.
// busy: create, delay and start hold busy for the OP step alone; a tick holds
//   it through the TICK, WALK, CHKRD and CHK steps (WALK skipped with no tasks),
//   the delay counters being walked one task per cycle through a single read
//   port. the result strobe rises in the same cycle that busy drops, when the
//   next command may already be accepted.
// reset: rst_n low clears the task table, all delays and idle counters.
module tick_round_robin_scheduler_top import trrs_pkg::*; #(
  parameter int TASKS = TASKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_op,
  input  logic [DLY_W-1:0]     in_delay_ms,
  output logic                 out_valid,
  output logic [OUT_IDX_W-1:0] out_running_task,
  output logic                 out_idle_selected,
  output logic                 out_create_failed,
  output logic [MEAS_W-1:0]    out_idle_measure
);

  ctl_t ctl;
  sts_t sts;
  logic accept;

  assign accept = start && !busy;

  trrs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  trrs_dp #(.TASKS(TASKS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .in_op             (in_op),
    .in_delay_ms       (in_delay_ms),
    .ctl               (ctl),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_running_task  (out_running_task),
    .out_idle_selected (out_idle_selected),
    .out_create_failed (out_create_failed),
    .out_idle_measure  (out_idle_measure)
  );

endmodule

/* verif/tick_round_robin_scheduler_top_tb.sv */
`timescale 1ns / 1ps
module tick_round_robin_scheduler_top_tb;
  import trrs_pkg::*;

  localparam int N_TASKS = TASKS_DEF;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] running;
    logic                 idle;
    logic                 failed;
    logic [MEAS_W-1:0]    measure;
  } sel_res_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [DLY_W-1:0] dly;
    logic             typed;
    sel_res_t         res;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_op = OP_TICK;
  logic [DLY_W-1:0]     in_delay_ms = '0;
  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_running_task;
  logic                 out_idle_selected;
  logic                 out_create_failed;
  logic [MEAS_W-1:0]    out_idle_measure;

  // selector state tracked alongside the block
  logic [1:0]        cur_idx;
  logic [1:0]        pre_idx;
  logic [2:0]        n_tasks;
  logic              idling;
  logic [DLY_W-1:0]  dly_left [N_TASKS];
  logic              armed [N_TASKS];
  logic [MEAS_W-1:0] win_ticks;
  logic [MEAS_W-1:0] idle_cnt;
  logic [MEAS_W-1:0] idle_meas;

  sel_res_t pending_sel [$];
  int       mismatches = 0;
  int       beats_sent = 0;
  int       stall_pct = 0;

  always #1 clk = ~clk;

  tick_round_robin_scheduler_top #(.TASKS(N_TASKS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_delay_ms      (in_delay_ms),
    .out_valid        (out_valid),
    .out_running_task (out_running_task),
    .out_idle_selected(out_idle_selected),
    .out_create_failed(out_create_failed),
    .out_idle_measure (out_idle_measure)
  );

  function automatic int slot_of(input int idx);
    return (idx < N_TASKS) ? idx : 0;
  endfunction

  task automatic predict_selection(input logic [1:0] op, input logic [DLY_W-1:0] dly,
                                   output sel_res_t r);
    int   nxt;
    int   i;
    logic fail;
    fail = 1'b0;
    case (op)
      OP_TICK: begin
        // resume from the preempted task when idle was running
        nxt = idling ? pre_idx : cur_idx;
        idling = 1'b0;
        nxt++;
        if (nxt >= n_tasks || nxt >= N_TASKS) nxt = 0;
        cur_idx = 2'(nxt);
        for (i = 0; i < n_tasks && i < N_TASKS; i++)
          if (dly_left[i] != '0) dly_left[i]--;
        win_ticks++;
        if (win_ticks >= WINDOW_LEN) begin
          idle_meas = idle_cnt;
          idle_cnt = '0;
          win_ticks = '0;
        end
        nxt = slot_of(nxt);
        if (armed[nxt]) begin
          if (dly_left[nxt] != '0) begin
            pre_idx = 2'(nxt);
            idling = 1'b1;
            if (idle_cnt < COUNT_MAX) idle_cnt++;
          end else begin
            armed[nxt] = 1'b0;
          end
        end
      end
      OP_CREATE: begin
        if (n_tasks >= N_TASKS) begin
          fail = 1'b1;
        end else begin
          cur_idx = 2'(n_tasks);
          armed[slot_of(n_tasks)] = 1'b0;
          n_tasks++;
          idling = 1'b0;
        end
      end
      OP_DELAY: begin
        if (!idling) begin
          dly_left[slot_of(cur_idx)] = dly;
          armed[slot_of(cur_idx)] = 1'b1;
        end
      end
      default: begin
        cur_idx = '0;
        idling = 1'b0;
        win_ticks = '0;
        idle_cnt = '0;
        idle_meas = '0;
      end
    endcase
    r.running = cur_idx;
    r.idle = idling;
    r.failed = fail;
    r.measure = idle_meas;
  endtask

  task automatic issue_cmd(input logic [1:0] op, input logic [DLY_W-1:0] dly,
                           input bit typed = 1'b0, input sel_res_t want = '0);
    sel_res_t r;
    bit       taken;
    taken = 1'b0;
    // stall draw every cycle so gaps land on every step of a running command
    while (!taken) begin
      start <= ($urandom_range(99) >= stall_pct);
      in_op <= op;
      in_delay_ms <= dly;
      @(posedge clk);
      taken = start && !busy;
    end
    predict_selection(op, dly, r);
    pending_sel.push_back(typed ? want : r);
    beats_sent++;
  endtask

  task automatic tick_burst(input int n);
    repeat (n) issue_cmd(OP_TICK, 16'($urandom));
  endtask

  task automatic random_traffic(input int n);
    int goal;
    int kind;
    goal = beats_sent + n;
    while (beats_sent < goal) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        tick_burst($urandom_range(1, 6));
      end else if (kind < 75) begin
        // arm a short countdown and tick one to eight times after it
        issue_cmd(OP_DELAY, 16'($urandom_range(0, 10)));
        tick_burst($urandom_range(1, 8));
      end else if (kind < 82) begin
        // wide value then overwrite, so no task stays parked for ages
        issue_cmd(OP_DELAY, 16'($urandom));
        issue_cmd(OP_DELAY, 16'($urandom_range(0, 10)));
      end else if (kind < 88) begin
        issue_cmd(OP_START, 16'($urandom));
      end else if (kind < 94) begin
        issue_cmd(OP_CREATE, 16'($urandom));
      end else begin
        issue_cmd(2'($urandom), 16'($urandom_range(0, 31)));
      end
    end
  endtask

  always @(posedge clk) begin
    sel_res_t e;
    if (rst_n && out_valid) begin
      if (pending_sel.size() == 0) begin
        $display("%0t: result beat with nothing pending, running_task %0d idle %0d",
                 $time, out_running_task, out_idle_selected);
        mismatches++;
      end else begin
        e = pending_sel.pop_front();
        if (out_running_task !== e.running) begin
          $display("%0t: running_task expected %0d got %0d", $time, e.running,
                   out_running_task);
          mismatches++;
        end
        if (out_idle_selected !== e.idle) begin
          $display("%0t: idle_selected expected %0d got %0d", $time, e.idle,
                   out_idle_selected);
          mismatches++;
        end
        if (out_create_failed !== e.failed) begin
          $display("%0t: create_failed expected %0d got %0d", $time, e.failed,
                   out_create_failed);
          mismatches++;
        end
        if (out_idle_measure !== e.measure) begin
          $display("%0t: idle_measure expected %0d got %0d", $time, e.measure,
                   out_idle_measure);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cmd_row_t dir_tab [DIR_ROWS];
    int       k;
    dir_tab = '{
      '{OP_TICK,   16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}}, // no tasks yet
      '{OP_DELAY,  16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}}, // lands on task 0
      '{OP_TICK,   16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}}, // zero length, no idle
      '{OP_DELAY,  16'd5,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}},
      '{OP_TICK,   16'd0,      1'b1, '{2'd0, 1'b1, 1'b0, 10'd0}}, // idle with no tasks
      '{OP_DELAY,  16'd7,      1'b1, '{2'd0, 1'b1, 1'b0, 10'd0}}, // ignored while idle
      '{OP_CREATE, 16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}}, // create ends idle
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_DELAY,  16'hffff,   1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_START,  16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}},
      '{OP_CREATE, 16'd0,      1'b1, '{2'd1, 1'b0, 1'b0, 10'd0}},
      '{OP_CREATE, 16'd0,      1'b1, '{2'd2, 1'b0, 1'b0, 10'd0}},
      '{OP_CREATE, 16'd0,      1'b1, '{2'd3, 1'b0, 1'b0, 10'd0}},
      '{OP_CREATE, 16'hffff,   1'b1, '{2'd3, 1'b0, 1'b1, 10'd0}}, // table full
      '{OP_START,  16'd0,      1'b1, '{2'd0, 1'b0, 1'b0, 10'd0}},
      '{OP_DELAY,  16'd0,      1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_TICK,   16'd0,      1'b0, '0},
      '{OP_DELAY,  16'h5555,   1'b0, '0},
      '{OP_DELAY,  16'haaaa,   1'b0, '0},
      '{OP_DELAY,  16'd3,      1'b0, '0}
    };
    cur_idx = '0;
    pre_idx = '0;
    n_tasks = '0;
    idling = 1'b0;
    for (k = 0; k < N_TASKS; k++) begin
      dly_left[k] = '0;
      armed[k] = 1'b0;
    end
    win_ticks = '0;
    idle_cnt = '0;
    idle_meas = '0;

    stall_pct = 9;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < DIR_ROWS; k++)
      issue_cmd(dir_tab[k].op, dir_tab[k].dly, dir_tab[k].typed, dir_tab[k].res);
    random_traffic(270);
    stall_pct = 46;
    random_traffic(270);
    stall_pct = 0;
    random_traffic(270);

    // let short countdowns drain, then park all four tasks and keep ticking in idle
    tick_burst(20);
    issue_cmd(OP_START, 16'd0);
    repeat (N_TASKS) begin
      issue_cmd(OP_DELAY, 16'hffff);
      issue_cmd(OP_TICK, 16'd0);
    end
    tick_burst(40);
    start <= 1'b0;

    while (pending_sel.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
